// ----- hdl/phqm_pkg.sv -----
// Package for the per-host traffic quota meter: widths, commands, queue entry type.
// No dependencies.
`default_nettype none
package phqm_pkg;
	localparam int TableEntries = 16;
	localparam int IdxW = $clog2(TableEntries);
	localparam int ResW = 20;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		CMD_EGRESS = 2'd0,
		CMD_INGRESS = 2'd1,
		CMD_LOAD = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] entry_index;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] packet_length;
		logic on_lan_bridge;
		logic locally_originated;
		logic conn_new_or_related;
		logic [31:0] entry_host_address;
		logic signed [31:0] entry_limit_mb;
		logic entry_auto_block;
		logic entry_enable;
	} item_t;

	typedef struct packed {
		logic drop;
		logic [31:0] total_wan_mb;
		logic charged;
		logic [3:0] charged_index;
		logic signed [31:0] remaining_mb;
	} result_t;

	// front-to-back job: item plus WAN total already computed by the front
	typedef struct packed {
		item_t item;
		logic [31:0] wan_total;
	} job_t;
endpackage
`default_nettype wire

// ----- hdl/phqm_if.sv -----
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type given by parameter.
`default_nettype none
interface phqm_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/phqm_front.sv -----
// Front part: accepts items, keeps the WAN residue and total, queues jobs.
// Depends on phqm_pkg.
`default_nettype none
module phqm_front import phqm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire item_t in_data,
	output logic q_valid,
	input wire logic q_pop,
	output job_t q_data
);
	job_t mem_q [QDepth];
	logic [$clog2(QDepth)-1:0] wr_q, rd_q;
	logic [$clog2(QDepth):0] cnt_q;
	logic [ResW-1:0] wres_q;
	logic [31:0] wtot_q;
	logic [ResW:0] sum;
	logic [31:0] tot_n;
	logic push, wan;

	assign in_ready = (cnt_q != QDepth[$clog2(QDepth):0]);
	assign push = in_valid && in_ready;
	assign wan = !in_data.on_lan_bridge &&
		(in_data.cmd == CMD_EGRESS || in_data.cmd == CMD_INGRESS);
	assign sum = {1'b0, wres_q} + {5'd0, in_data.packet_length};
	assign tot_n = wtot_q + {31'd0, sum[ResW]};
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			wres_q <= '0;
			wtot_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
				if (wan) begin
					wres_q <= sum[ResW-1:0];
					wtot_q <= tot_n;
				end
			end
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].item <= in_data;
			mem_q[wr_q].wan_total <= wan ? tot_n : wtot_q;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/phqm_back.sv -----
// Back part: walks the host table one slot a cycle, charges and delivers result.
// Depends on phqm_pkg.
`default_nettype none
module phqm_back import phqm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire job_t q_data,
	output logic out_valid,
	input wire logic out_ready,
	output result_t out_data
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_CHARGE = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t st_q;
	logic [31:0] addr_q [TableEntries];
	logic signed [31:0] bud_q [TableEntries];
	logic [ResW-1:0] res_q [TableEntries];
	logic [TableEntries-1:0] ab_q, vld_q;
	job_t job_q;
	logic [IdxW-1:0] i_q, hit_q, dflt_q;
	logic hitv_q, dfltv_q;
	result_t res_out_q;
	logic [ResW:0] hsum;
	logic signed [32:0] nb;
	logic signed [31:0] nbs;
	logic match, last;

	assign match = vld_q[i_q] && (addr_q[i_q] == job_q.item.dest_address ||
		addr_q[i_q] == job_q.item.source_address);
	assign last = (i_q == IdxW'(TableEntries - 1));
	assign hsum = {1'b0, res_q[hit_q]} + {5'd0, job_q.item.packet_length};
	assign nb = {bud_q[hit_q][31], bud_q[hit_q]} - {32'd0, hsum[ResW]};
	assign nbs = (nb < -33'sd2147483648) ? 32'sh80000000 : nb[31:0];
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign out_valid = (st_q == ST_OUT);
	assign out_data = res_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vld_q <= '0;
			ab_q <= '0;
			i_q <= '0;
			hitv_q <= 1'b0;
			dfltv_q <= 1'b0;
			for (int k = 0; k < TableEntries; k++) begin
				addr_q[k] <= '0;
				bud_q[k] <= '0;
				res_q[k] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						job_q <= q_data;
						res_out_q <= '{drop: 1'b0, total_wan_mb: q_data.wan_total,
							charged: 1'b0, charged_index: '0, remaining_mb: '0};
						i_q <= '0;
						hitv_q <= 1'b0;
						dfltv_q <= 1'b0;
						st_q <= ST_OUT;
						if (q_data.item.cmd == CMD_LOAD) begin
							if (32'(q_data.item.entry_index) < TableEntries) begin
								addr_q[IdxW'(q_data.item.entry_index)] <=
									q_data.item.entry_host_address;
								bud_q[IdxW'(q_data.item.entry_index)] <=
									q_data.item.entry_limit_mb;
								res_q[IdxW'(q_data.item.entry_index)] <= '0;
								ab_q[IdxW'(q_data.item.entry_index)] <=
									q_data.item.entry_auto_block;
								vld_q[IdxW'(q_data.item.entry_index)] <=
									q_data.item.entry_enable;
							end
						end else if (q_data.item.cmd == CMD_EGRESS &&
							!q_data.item.locally_originated) begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q <= i_q;
						hitv_q <= 1'b1;
						st_q <= ST_CHARGE;
					end else begin
						if (vld_q[i_q] && addr_q[i_q] == '0) begin
							dflt_q <= i_q;
							dfltv_q <= 1'b1;
						end
						if (last) begin
							if (vld_q[i_q] && addr_q[i_q] == '0) begin
								hit_q <= i_q;
								hitv_q <= 1'b1;
							end else begin
								hit_q <= dflt_q;
								hitv_q <= dfltv_q;
							end
							st_q <= ST_CHARGE;
						end
						i_q <= i_q + 1'b1;
					end
				end
				ST_CHARGE: begin
					if (hitv_q) begin
						res_q[hit_q] <= hsum[ResW-1:0];
						bud_q[hit_q] <= nbs;
						res_out_q.drop <= (nbs <= 0) &&
							(ab_q[hit_q] || job_q.item.conn_new_or_related);
						res_out_q.charged <= 1'b1;
						res_out_q.charged_index <= 4'(hit_q);
						res_out_q.remaining_mb <= nbs;
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_charged_has_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.charged |-> out_data.charged_index == '0 &&
		out_data.remaining_mb == '0) else $error("uncharged result carries slot data");
	a_drop_needs_charge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drop |-> out_data.charged)
		else $error("drop without charge");
	a_drop_budget: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drop |-> out_data.remaining_mb <= 0)
		else $error("drop with positive budget");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

// ----- hdl/per_host_traffic_quota_meter_unit.sv -----
// Top level of the per-host traffic quota meter.
// Load, ingress, local and unused-command items go from idle straight to the output state; a scan adds scan and charge.
// The back takes a new item only once the last result is taken; the table walk covers one slot a cycle.
// A two-entry job queue lets the front take items while the back scans.
// Reset (arst_n low) clears the table, valid bits, WAN residue and total at once.
// Depends on phqm_pkg, phqm_if, phqm_front, phqm_back.
`default_nettype none
module per_host_traffic_quota_meter_unit import phqm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	phqm_if.sink in_ch,
	phqm_if.source out_ch
);
	logic q_valid, q_pop;
	job_t q_data;
	item_t in_item;
	result_t out_res;

	assign in_item = in_ch.data;
	assign out_ch.data = out_res;

	phqm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	phqm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_res)
	);
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the per-host traffic quota meter: packets and slot loads in,
// one verdict beat out per item. Depends on phqm_pkg, phqm_if and the unit top.
`timescale 1ns / 1ps
module testbench;
	import phqm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;

	phqm_if #(.T(item_t)) in_ch (clk);
	phqm_if #(.T(result_t)) out_ch (clk);

	per_host_traffic_quota_meter_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// meter state kept by the bench
	logic [31:0] m_addr [TableEntries];
	logic signed [31:0] m_budget [TableEntries];
	logic [19:0] m_res [TableEntries];
	logic m_auto [TableEntries];
	logic m_valid [TableEntries];
	logic [19:0] m_wan_res;
	logic [31:0] m_wan_mb;

	item_t pending_items[$];
	result_t expected_verdicts[$];
	bit stim_done = 1'b0;
	bit quiet = 1'b0;

	function automatic logic [31:0] carry_mb(inout logic [19:0] res, input logic [15:0] len);
		logic [31:0] sum;
		sum = {12'd0, res} + {16'd0, len};
		res = sum[19:0];
		return sum >> 20;
	endfunction

	function automatic result_t meter_verdict(item_t it);
		result_t r;
		int hit, dflt;
		logic [31:0] mb;
		longint v;
		r = '0;
		hit = -1;
		dflt = -1;
		if (it.cmd == CMD_LOAD) begin
			m_addr[it.entry_index] = it.entry_host_address;
			m_budget[it.entry_index] = it.entry_limit_mb;
			m_res[it.entry_index] = '0;
			m_auto[it.entry_index] = it.entry_auto_block;
			m_valid[it.entry_index] = it.entry_enable;
		end else if (it.cmd == CMD_INGRESS || it.cmd == CMD_EGRESS) begin
			if (!it.on_lan_bridge) m_wan_mb += carry_mb(m_wan_res, it.packet_length);
			if (it.cmd == CMD_EGRESS && !it.locally_originated) begin
				for (int i = 0; i < TableEntries; i++) begin
					if (m_valid[i]) begin
						if (m_addr[i] == 0) dflt = i;
						if (m_addr[i] == it.dest_address || m_addr[i] == it.source_address) begin
							hit = i;
							break;
						end
					end
				end
				if (hit < 0) hit = dflt;
				if (hit >= 0) begin
					mb = carry_mb(m_res[hit], it.packet_length);
					v = longint'(m_budget[hit]) - longint'(mb);
					if (v < -64'sd2147483648) v = -64'sd2147483648;
					m_budget[hit] = v[31:0];
					r.drop = (m_budget[hit] <= 0) && (m_auto[hit] || it.conn_new_or_related);
					r.charged = 1'b1;
					r.charged_index = hit[3:0];
					r.remaining_mb = m_budget[hit];
				end
			end
		end
		r.total_wan_mb = m_wan_mb;
		return r;
	endfunction

	function automatic item_t mk_item(cmd_t c);
		item_t it;
		it = '0;
		it.cmd = c;
		it.entry_index = 4'($urandom_range(0, 15));
		it.source_address = $urandom;
		it.dest_address = $urandom;
		it.packet_length = 16'($urandom);
		it.on_lan_bridge = 1'($urandom);
		it.locally_originated = 1'($urandom);
		it.conn_new_or_related = 1'($urandom);
		it.entry_host_address = $urandom;
		it.entry_limit_mb = $urandom;
		it.entry_auto_block = 1'($urandom);
		it.entry_enable = 1'($urandom);
		return it;
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(0, 99) < 13);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) expected_verdicts.push_back(meter_verdict(in_ch.data));
			if (pending_items.size() > 0 && !idle_now()) begin
				in_ch.data <= pending_items.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected beat %p", $time, out_ch.data);
					failed = 1'b1;
				end else begin
					result_t e;
					e = expected_verdicts.pop_front();
					if (e.drop !== out_ch.data.drop)
						$display("%0t: drop exp %0d got %0d", $time, e.drop, out_ch.data.drop);
					if (e.total_wan_mb !== out_ch.data.total_wan_mb)
						$display("%0t: total_wan_mb exp %0d got %0d", $time, e.total_wan_mb,
							out_ch.data.total_wan_mb);
					if (e.charged !== out_ch.data.charged)
						$display("%0t: charged exp %0d got %0d", $time, e.charged,
							out_ch.data.charged);
					if (e.charged_index !== out_ch.data.charged_index)
						$display("%0t: charged_index exp %0d got %0d", $time, e.charged_index,
							out_ch.data.charged_index);
					if (e.remaining_mb !== out_ch.data.remaining_mb)
						$display("%0t: remaining_mb exp %0d got %0d", $time, e.remaining_mb,
							out_ch.data.remaining_mb);
					if (e !== out_ch.data) failed = 1'b1;
				end
			end
			out_ch.ready <= !idle_now();
		end
	end

	task automatic load_slot(int idx, logic [31:0] addr, logic signed [31:0] lim, bit ab, bit en);
		item_t it;
		it = mk_item(CMD_LOAD);
		it.entry_index = 4'(idx);
		it.entry_host_address = addr;
		it.entry_limit_mb = lim;
		it.entry_auto_block = ab;
		it.entry_enable = en;
		pending_items.push_back(it);
	endtask

	task automatic send_pkt(cmd_t c, logic [31:0] src, logic [31:0] dst, logic [15:0] len,
		bit br, bit loc, bit nr);
		item_t it;
		it = mk_item(c);
		it.source_address = src;
		it.dest_address = dst;
		it.packet_length = len;
		it.on_lan_bridge = br;
		it.locally_originated = loc;
		it.conn_new_or_related = nr;
		pending_items.push_back(it);
	endtask

	initial begin
		logic [31:0] hosts [4];
		item_t it;
		int r;
		for (int i = 0; i < TableEntries; i++) begin
			m_addr[i] = '0;
			m_budget[i] = '0;
			m_res[i] = '0;
			m_auto[i] = 1'b0;
			m_valid[i] = 1'b0;
		end
		m_wan_res = '0;
		m_wan_mb = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, budget reaching zero, default slot, unused command
		send_pkt(CMD_EGRESS, 32'h0, 32'h0, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_pkt(CMD_INGRESS, '1, '1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		send_pkt(CMD_INGRESS, '1, '1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		load_slot(0, 32'h0A000001, 32'sd1, 1'b0, 1'b1);
		load_slot(15, 32'h0, -32'sd2147483648, 1'b1, 1'b1);
		load_slot(3, 32'h0, 32'sd2147483647, 1'b0, 1'b1);
		load_slot(5, '1, 32'sd0, 1'b0, 1'b1);
		for (int k = 0; k < 20; k++)
			send_pkt(CMD_EGRESS, 32'h0A000001, 32'h5, 16'hFFFF, 1'b0, 1'b0, k[0]);
		send_pkt(CMD_EGRESS, 32'h7, '1, 16'd0, 1'b1, 1'b0, 1'b0);
		send_pkt(CMD_EGRESS, 32'h7, 32'h8, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_pkt(CMD_EGRESS, 32'h7, 32'h8, 16'hFFFF, 1'b0, 1'b1, 1'b1);
		pending_items.push_back(mk_item(CMD_NONE));
		load_slot(15, 32'h0, 32'sd0, 1'b0, 1'b0);
		send_pkt(CMD_EGRESS, 32'h9, 32'h8, 16'h1234, 1'b0, 1'b0, 1'b1);

		// random: a small host set so lookups hit; most loads keep budgets small
		for (int h = 0; h < 4; h++) hosts[h] = (h == 0) ? 32'h0 : $urandom;
		for (int n = 0; n < 450; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				it = mk_item(CMD_LOAD);
				it.entry_host_address = ($urandom_range(0, 7) == 0) ? $urandom
					: hosts[$urandom_range(0, 3)];
				if ($urandom_range(0, 3) != 0) it.entry_limit_mb = $urandom_range(0, 6) - 2;
				it.entry_enable = ($urandom_range(0, 4) != 0);
			end else if (r < 85) begin
				it = mk_item(CMD_EGRESS);
				if ($urandom_range(0, 3) != 0) it.source_address = hosts[$urandom_range(0, 3)];
				if ($urandom_range(0, 3) != 0) it.dest_address = hosts[$urandom_range(0, 3)];
				it.locally_originated = ($urandom_range(0, 4) == 0);
			end else if (r < 97) begin
				it = mk_item(CMD_INGRESS);
			end else begin
				it = mk_item(CMD_NONE);
			end
			pending_items.push_back(it);
			if (n == 150) begin
				wait (pending_items.size() == 0);
				quiet = 1'b1;
			end
			if (n == 250) begin
				wait (pending_items.size() == 0);
				quiet = 1'b0;
			end
		end

		wait (pending_items.size() == 0 && !in_ch.valid);
		wait (expected_verdicts.size() == 0);
		repeat (40) @(posedge clk);
		if (!failed && expected_verdicts.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
